// ===== rtl/dblt_pkg.sv =====
package dblt_pkg;

  localparam int unsigned DEB_W  = 10;
  localparam int unsigned ON_W   = 20;
  localparam int unsigned HOLD_W = 16;
  localparam int unsigned CFG_W  = 20;
  localparam int unsigned IDX_W  = 2;

  localparam logic [DEB_W-1:0]  DEB_RESET  = DEB_W'(80);
  localparam logic [ON_W-1:0]   ON_RESET   = ON_W'(10000);
  localparam logic [HOLD_W-1:0] HOLD_RESET = HOLD_W'(1920);

  typedef enum logic [IDX_W-1:0] {
    REG_DEBOUNCE = 2'd0,
    REG_ON_TIME  = 2'd1,
    REG_HOLD     = 2'd2
  } reg_idx_t;

  typedef struct packed {
    logic [DEB_W-1:0]  debounce_ticks;
    logic [ON_W-1:0]   on_time_ticks;
    logic [HOLD_W-1:0] hold_ticks;
  } cfg_t;

  typedef struct packed {
    logic light_on;
    logic edge_armed;
    logic deb_idle;
  } tick_status_t;

endpackage

// ===== rtl/dblt_in_if.sv =====
interface dblt_in_if;
  logic valid;
  logic ready;
  logic button_level;

  modport source (output valid, output button_level, input ready);
  modport sink   (input valid, input button_level, output ready);
endinterface

// ===== rtl/dblt_out_if.sv =====
interface dblt_out_if;
  logic valid;
  logic ready;
  logic led_on;

  modport source (output valid, output led_on, input ready);
  modport sink   (input valid, input led_on, output ready);
endinterface

// ===== rtl/dblt_cfg.sv =====
module dblt_cfg
  import dblt_pkg::*;
(
  input  logic             clk,
  input  logic             rst_n,
  input  logic             cfg_we,
  input  logic [IDX_W-1:0] cfg_index,
  input  logic [CFG_W-1:0] cfg_wdata,
  output cfg_t             cfg
);

  cfg_t cfg_r;

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      cfg_r.debounce_ticks <= DEB_RESET;
      cfg_r.on_time_ticks  <= ON_RESET;
      cfg_r.hold_ticks     <= HOLD_RESET;
    end else if (cfg_we) begin
      case (cfg_index)
        REG_DEBOUNCE: cfg_r.debounce_ticks <= cfg_wdata[DEB_W-1:0];
        REG_ON_TIME:  cfg_r.on_time_ticks  <= cfg_wdata[ON_W-1:0];
        REG_HOLD:     cfg_r.hold_ticks     <= cfg_wdata[HOLD_W-1:0];
        default: ;
      endcase
    end
  end

  assign cfg = cfg_r;

endmodule

// ===== rtl/dblt_tick.sv =====
module dblt_tick
  import dblt_pkg::*;
(
  input  logic         clk,
  input  logic         rst_n,
  input  cfg_t         cfg,
  input  logic         tick_en,
  input  logic         level,
  output logic         led_nxt,
  output tick_status_t status
);

  logic              light_r, last_r, armed_r;
  logic [DEB_W-1:0]  deb_r;
  logic [ON_W-1:0]   on_r;
  logic [HOLD_W-1:0] hold_r;

  logic              light_nxt, last_nxt, armed_nxt;
  logic [DEB_W-1:0]  deb_nxt;
  logic [ON_W-1:0]   on_nxt;
  logic [HOLD_W-1:0] hold_nxt;

  logic deb_exp, on_exp, hold_exp;

  // a zero setting loads as one
  logic [DEB_W-1:0]  deb_load;
  logic [ON_W-1:0]   on_load;
  logic [HOLD_W-1:0] hold_load;

  assign deb_load  = (cfg.debounce_ticks == '0) ? DEB_W'(1)  : cfg.debounce_ticks;
  assign on_load   = (cfg.on_time_ticks  == '0) ? ON_W'(1)   : cfg.on_time_ticks;
  assign hold_load = (cfg.hold_ticks     == '0) ? HOLD_W'(1) : cfg.hold_ticks;

  assign deb_exp  = (deb_r  == DEB_W'(1));
  assign on_exp   = (on_r   == ON_W'(1));
  assign hold_exp = (hold_r == HOLD_W'(1));

  always_comb begin
    deb_nxt   = (deb_r  != '0) ? deb_r  - DEB_W'(1)  : deb_r;
    on_nxt    = (on_r   != '0) ? on_r   - ON_W'(1)   : on_r;
    hold_nxt  = (hold_r != '0) ? hold_r - HOLD_W'(1) : hold_r;
    light_nxt = light_r;
    armed_nxt = armed_r;

    // debounce expiry samples the pin (0 = pressed)
    if (deb_exp) begin
      if (!level) begin
        on_nxt = on_load;
        if (light_r) begin
          if (hold_nxt == '0) begin
            hold_nxt = hold_load;
          end
        end else begin
          light_nxt = 1'b1;
        end
      end else begin
        hold_nxt = '0;
      end
      armed_nxt = 1'b1;
    end

    if (on_exp) begin
      light_nxt = 1'b0;
    end

    if (hold_exp) begin
      light_nxt = 1'b0;
      on_nxt    = '0;
    end

    if (armed_nxt && (level != last_r)) begin
      armed_nxt = 1'b0;
      deb_nxt   = deb_load;
    end
    last_nxt = level;
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      light_r <= 1'b0;
      last_r  <= 1'b1;
      armed_r <= 1'b1;
      deb_r   <= '0;
      on_r    <= '0;
      hold_r  <= '0;
    end else if (tick_en) begin
      light_r <= light_nxt;
      last_r  <= last_nxt;
      armed_r <= armed_nxt;
      deb_r   <= deb_nxt;
      on_r    <= on_nxt;
      hold_r  <= hold_nxt;
    end
  end

  assign led_nxt           = light_nxt;
  assign status.light_on   = light_r;
  assign status.edge_armed = armed_r;
  assign status.deb_idle   = (deb_r == '0);

endmodule

// ===== rtl/debounced_button_light_timer.sv =====
// debounced staircase light timer with hold-to-switch-off
//
// in_chan carries one tick (one millisecond) per transfer with the raw
// active-low button level; out_chan returns one transfer per tick with the
// LED level after that tick, in order
// cfg port: cfg_we writes cfg_wdata to register cfg_index at the clock edge
//   0 debounce ticks, 1 on-time ticks, 2 hold ticks; other indexes ignored
//   write only while no tick is in flight
// path: a tick passes the input register, then the result register, and
//   its result is offered from the result register
// throughput: one tick per cycle while the receiver takes results; the tick
//   state updates in one pass of short logic as a tick moves from the input
//   register to the result register
// a stalled receiver holds the result register; the input register still
//   takes one more tick, then in_chan.ready drops until the result moves
// reset (rst_n low, synchronous): LED off, button released, edge detection
//   armed, all counters stopped, registers back to 80 / 10000 / 1920
module debounced_button_light_timer
  import dblt_pkg::*;
(
  input  logic             clk,
  input  logic             rst_n,
  dblt_in_if.sink          in_chan,
  dblt_out_if.source       out_chan,
  input  logic             cfg_we,
  input  logic [IDX_W-1:0] cfg_index,
  input  logic [CFG_W-1:0] cfg_wdata
);

  cfg_t         cfg;
  tick_status_t status;

  // input register
  logic s1_valid_r, s1_level_r;
  // result register
  logic out_valid_r, led_r;
  logic led_nxt;
  logic adv;

  // tick moves on when the result register is free or being drained
  assign adv = s1_valid_r && (!out_valid_r || out_chan.ready);

  assign in_chan.ready = !s1_valid_r || adv;

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      s1_valid_r <= 1'b0;
    end else if (in_chan.ready) begin
      s1_valid_r <= in_chan.valid;
    end
  end

  always_ff @(posedge clk) begin
    if (in_chan.ready && in_chan.valid) begin
      s1_level_r <= in_chan.button_level;
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      out_valid_r <= 1'b0;
    end else if (adv) begin
      out_valid_r <= 1'b1;
    end else if (out_chan.ready) begin
      out_valid_r <= 1'b0;
    end
  end

  always_ff @(posedge clk) begin
    if (adv) begin
      led_r <= led_nxt;
    end
  end

  assign out_chan.valid  = out_valid_r;
  assign out_chan.led_on = led_r;

  dblt_cfg u_cfg (
    .clk       (clk),
    .rst_n     (rst_n),
    .cfg_we    (cfg_we),
    .cfg_index (cfg_index),
    .cfg_wdata (cfg_wdata),
    .cfg       (cfg)
  );

  dblt_tick u_tick (
    .clk     (clk),
    .rst_n   (rst_n),
    .cfg     (cfg),
    .tick_en (adv),
    .level   (s1_level_r),
    .led_nxt (led_nxt),
    .status  (status)
  );

  // debounce runs exactly while edge detection is disarmed
  a_armed_idle: assert property (@(posedge clk) disable iff (!rst_n)
    status.edge_armed == status.deb_idle)
    else $error("edge detection and debounce counter disagree");

  // a tick that moves on always leaves a result to offer
  a_adv_result: assert property (@(posedge clk) disable iff (!rst_n)
    adv |=> out_valid_r)
    else $error("tick advanced without a result");

  // light state changes only on a tick
  a_light_tick: assert property (@(posedge clk) disable iff (!rst_n)
    !adv |=> $stable(status.light_on))
    else $error("light changed without a tick");

  // the offered LED level matches the light state after its tick
  a_led_match: assert property (@(posedge clk) disable iff (!rst_n)
    adv |=> (led_r == status.light_on))
    else $error("result disagrees with light state");

endmodule

// ===== dv/debounced_button_light_timer_tb.sv =====
module debounced_button_light_timer_tb;
  timeunit 1ns;
  timeprecision 1ps;

  import dblt_pkg::*;

  // index past the last register, writes to it must leave everything alone
  localparam logic [IDX_W-1:0] REG_UNUSED = 2'd3;

  // tracks the lamp state tick by tick and holds the led levels still owed
  class lamp_tracker;
    bit [DEB_W-1:0]  deb_ticks;
    bit [ON_W-1:0]   on_ticks;
    bit [HOLD_W-1:0] hold_ticks;

    bit              lit;
    bit              last_level;
    bit              armed;
    bit [DEB_W-1:0]  deb_left;
    bit [ON_W-1:0]   on_left;
    bit [HOLD_W-1:0] hold_left;

    bit              led_due[$];
    int              failures;

    function new();
      deb_ticks  = DEB_RESET;
      on_ticks   = ON_RESET;
      hold_ticks = HOLD_RESET;
      lit        = 1'b0;
      last_level = 1'b1;
      armed      = 1'b1;
      deb_left   = '0;
      on_left    = '0;
      hold_left  = '0;
      failures   = 0;
    endfunction

    function void set_reg(logic [IDX_W-1:0] idx, logic [CFG_W-1:0] data);
      case (idx)
        REG_DEBOUNCE: deb_ticks = data[DEB_W-1:0];
        REG_ON_TIME:  on_ticks = data[ON_W-1:0];
        REG_HOLD:     hold_ticks = data[HOLD_W-1:0];
        default:      ;
      endcase
    endfunction

    // one tick: count down, then debounce, on-time and hold expiries, then edge check
    function bit predict_led(bit level);
      bit deb_fire, on_fire, hold_fire;
      deb_fire  = 1'b0;
      on_fire   = 1'b0;
      hold_fire = 1'b0;
      if (deb_left != 0) begin
        deb_left--;
        deb_fire = (deb_left == 0);
      end
      if (on_left != 0) begin
        on_left--;
        on_fire = (on_left == 0);
      end
      if (hold_left != 0) begin
        hold_left--;
        hold_fire = (hold_left == 0);
      end

      if (deb_fire) begin
        if (!level) begin
          // a zero setting loads as one
          on_left = (on_ticks == 0) ? ON_W'(1) : on_ticks;
          if (lit) begin
            if (hold_left == 0)
              hold_left = (hold_ticks == 0) ? HOLD_W'(1) : hold_ticks;
          end else begin
            lit = 1'b1;
          end
        end else begin
          hold_left = '0;
        end
        armed = 1'b1;
      end

      // expiry marks fire even if the counter was just reloaded
      if (on_fire)
        lit = 1'b0;
      if (hold_fire) begin
        lit     = 1'b0;
        on_left = '0;
      end

      if (armed && level != last_level) begin
        armed    = 1'b0;
        deb_left = (deb_ticks == 0) ? DEB_W'(1) : deb_ticks;
      end
      last_level = level;
      return lit;
    endfunction

    function void note_tick(bit level);
      led_due.push_back(predict_led(level));
    endfunction

    function void check_led(logic actual);
      bit want;
      if (led_due.size() == 0) begin
        $error("led_on: transfer with nothing expected, actual %0b", actual);
        failures++;
      end else begin
        want = led_due.pop_front();
        if (actual !== want) begin
          $error("led_on: expected %0b, actual %0b", want, actual);
          failures++;
        end
      end
    endfunction

    function int pending();
      return led_due.size();
    endfunction

    function void flag_leftover();
      if (led_due.size() != 0) begin
        $error("led_on: %0d expected transfers never arrived", led_due.size());
        failures++;
      end
    endfunction
  endclass

  logic clk = 1'b0;
  logic rst_n;
  logic             cfg_we;
  logic [IDX_W-1:0] cfg_index;
  logic [CFG_W-1:0] cfg_wdata;

  dblt_in_if  in_chan();
  dblt_out_if out_chan();

  debounced_button_light_timer DUT (
    .clk       (clk),
    .rst_n     (rst_n),
    .in_chan   (in_chan),
    .out_chan  (out_chan),
    .cfg_we    (cfg_we),
    .cfg_index (cfg_index),
    .cfg_wdata (cfg_wdata)
  );

  lamp_tracker sb = new();
  bit          pin = 1'b1;   // current raw button level being driven

  always #2ns clk = ~clk;

  // every result transfer is checked against the oldest owed led level
  always @(posedge clk) begin
    if (rst_n === 1'b1 && out_chan.valid === 1'b1 && out_chan.ready === 1'b1)
      sb.check_led(out_chan.led_on);
  end

  // receiver back-pressure: mostly short stalls, a few long ones,
  // now and then a long stretch of no stalls at all
  initial begin
    int r;
    out_chan.ready <= 1'b0;
    @(posedge clk);
    forever begin
      r = $urandom_range(0, 99);
      out_chan.ready <= 1'b1;
      if (r < 10) begin
        repeat ($urandom_range(100, 300)) @(posedge clk);
      end else begin
        repeat ($urandom_range(1, 12)) @(posedge clk);
        out_chan.ready <= 1'b0;
        r = $urandom_range(0, 99);
        if (r < 70)
          repeat ($urandom_range(1, 2)) @(posedge clk);
        else if (r < 95)
          repeat ($urandom_range(3, 8)) @(posedge clk);
        else
          repeat ($urandom_range(20, 60)) @(posedge clk);
      end
    end
  end

  // one tick transfer, then maybe an idle gap on the input side
  task automatic send_tick(bit level, bit quiet);
    int r;
    in_chan.valid        <= 1'b1;
    in_chan.button_level <= level;
    do @(posedge clk); while (in_chan.ready !== 1'b1);
    sb.note_tick(level);
    if (!quiet) begin
      r = $urandom_range(0, 99);
      if (r >= 70) begin
        in_chan.valid <= 1'b0;
        if (r < 92)
          repeat ($urandom_range(1, 3)) @(posedge clk);
        else
          repeat ($urandom_range(8, 30)) @(posedge clk);
      end
    end
  endtask

  task automatic send_pattern(string bits);
    for (int i = 0; i < bits.len(); i++) begin
      pin = (bits[i] == "1");
      send_tick(pin, 1'b0);
    end
  endtask

  // presses and releases of random length, about a quarter of them
  // short bounces that break the debounce window
  task automatic run_presses(int n, int long_run, bit quiet);
    int seg;
    int sent;
    sent = 0;
    while (sent < n) begin
      seg = ($urandom_range(0, 3) == 0) ? $urandom_range(1, 3)
                                        : $urandom_range(1, long_run);
      pin = ~pin;
      for (int k = 0; k < seg && sent < n; k++) begin
        send_tick(pin, quiet);
        sent++;
      end
    end
  endtask

  // block is idle once every owed result is out and the pipe has drained
  task automatic settle();
    in_chan.valid <= 1'b0;
    while (sb.pending() != 0) @(posedge clk);
    repeat (3) @(posedge clk);
  endtask

  // caller drops cfg_we after the last write of a batch
  task automatic cfg_write(logic [IDX_W-1:0] idx, logic [CFG_W-1:0] data);
    cfg_we    <= 1'b1;
    cfg_index <= idx;
    cfg_wdata <= data;
    sb.set_reg(idx, data);
    @(posedge clk);
  endtask

  // random bits above a register's width must be masked off
  task automatic load_timing(int deb, int on, int hold, bit garble);
    logic [CFG_W-1:0] data;
    data = garble ? CFG_W'($urandom()) : '0;
    data[DEB_W-1:0] = DEB_W'(deb);
    cfg_write(REG_DEBOUNCE, data);
    cfg_write(REG_ON_TIME, CFG_W'(on));
    data = garble ? CFG_W'($urandom()) : '0;
    data[HOLD_W-1:0] = HOLD_W'(hold);
    cfg_write(REG_HOLD, data);
    if ($urandom_range(0, 2) == 0)
      cfg_write(REG_UNUSED, CFG_W'($urandom()));
    cfg_we <= 1'b0;
  endtask

  initial begin
    int deb, on, hold;
    rst_n                <= 1'b0;
    in_chan.valid        <= 1'b0;
    in_chan.button_level <= 1'b1;
    cfg_we               <= 1'b0;
    cfg_index            <= REG_DEBOUNCE;
    cfg_wdata            <= '0;
    repeat (10) @(posedge clk);
    rst_n <= 1'b1;
    @(posedge clk);

    // reset timing: a press held through the 80 tick debounce lights the lamp
    pin = 1'b1;
    send_tick(pin, 1'b0);
    pin = 1'b0;
    repeat (84) send_tick(pin, 1'b0);

    // directed: zero debounce loads as one, short on-time and hold,
    // retrigger while lit, hold forcing the lamp off, release stopping hold,
    // bounces while disarmed, expiry and new edge in the same tick
    settle();
    cfg_write(REG_UNUSED, '1);
    load_timing(0, 4, 2, 1'b0);
    send_pattern("1100001100101111110100011");

    // random timing, mostly small so every counter expires often
    repeat (6) begin
      settle();
      deb  = $urandom_range(0, 6);
      on   = $urandom_range(0, 40);
      hold = $urandom_range(0, 20);
      load_timing(deb, on, hold, $urandom_range(0, 1));
      run_presses(25, deb + hold + on / 2 + 4, $urandom_range(0, 3) == 0);
    end

    // widest settings: all ones on the bus, masked per register;
    // then a short debounce with high bits set, so a press lights the lamp
    // with the huge on-time
    settle();
    cfg_write(REG_DEBOUNCE, '1);
    cfg_write(REG_ON_TIME, '1);
    cfg_write(REG_HOLD, '1);
    cfg_write(REG_DEBOUNCE, {{(CFG_W-DEB_W){1'b1}}, DEB_W'(3)});
    cfg_we <= 1'b0;
    pin = 1'b1;
    repeat (5) send_tick(pin, 1'b1);
    pin = 1'b0;
    repeat (30) send_tick(pin, 1'b1);

    // back to short timing, the huge on-time left over is cut by a reload
    // or by hold
    settle();
    load_timing(1, 20, 0, 1'b1);
    run_presses(60, 12, 1'b0);

    // every register at zero, each counter expires one tick after loading
    settle();
    load_timing(0, 0, 0, 1'b0);
    run_presses(40, 6, 1'b0);

    in_chan.valid <= 1'b0;
    for (int i = 0; i < 2000 && sb.pending() != 0; i++) @(posedge clk);
    repeat (4) @(posedge clk);
    sb.flag_leftover();
    if (sb.failures == 0)
      $display("No mismatches found");
    else
      $display("Mismatches found");
    $finish;
  end

  // hang guard, far beyond the slowest legal run
  initial begin
    #3ms;
    $display("Mismatches found");
    $finish;
  end

endmodule
